// ----- rtl/vrk_pkg.sv -----
`default_nettype none
package vrk_pkg;

    localparam int DW    = 32;
    localparam int FB    = 16;
    localparam int NCOEF = 18;

    typedef logic signed [DW-1:0]   t_word;
    typedef logic signed [2*DW-1:0] t_prod;
    typedef t_word [NCOEF-1:0]      t_tab;

    localparam t_word W_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam t_word W_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        CFG_TIME_STEP = 3'd0,
        CFG_MASS      = 3'd1,
        CFG_XU        = 3'd2,
        CFG_YV        = 3'd3,
        CFG_YR        = 3'd4,
        CFG_NV        = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic  ovf;
        t_word v;
    } t_sat;

    // per-item context that rides along the pipe
    typedef struct packed {
        t_word [2:0]      vel;
        t_word [2:0]      frc;
        t_word [2:0][2:0] k;
        logic             ovf;
    } t_ctx;

    typedef struct packed {
        t_word mass;
        t_word xu;
        t_word yv;
        t_word yrn;
        logic  yrn_ovf;
    } t_phys;

    function automatic t_sat f_add(t_word a, t_word b);
        logic [DW:0] s;
        t_sat        r;
        s     = {a[DW-1], a} + {b[DW-1], b};
        r.ovf = s[DW] ^ s[DW-1];
        r.v   = r.ovf ? (s[DW] ? W_MIN : W_MAX) : t_word'(s[DW-1:0]);
        return r;
    endfunction

    function automatic t_sat f_sub(t_word a, t_word b);
        logic [DW:0] s;
        t_sat        r;
        s     = {a[DW-1], a} - {b[DW-1], b};
        r.ovf = s[DW] ^ s[DW-1];
        r.v   = r.ovf ? (s[DW] ? W_MIN : W_MAX) : t_word'(s[DW-1:0]);
        return r;
    endfunction

    function automatic t_prod f_mul(t_word a, t_word b);
        t_prod wa;
        t_prod wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    // floor shift by FB, then saturate
    function automatic t_sat f_mulsat(t_prod p);
        t_prod           q;
        logic [DW:0]     hi;
        t_sat            r;
        q     = p >>> FB;
        hi    = q[2*DW-1:DW-1];
        r.ovf = !((&hi) || !(|hi));
        r.v   = r.ovf ? (q[2*DW-1] ? W_MIN : W_MAX) : t_word'(q[DW-1:0]);
        return r;
    endfunction

    function automatic t_word f_half(t_word x);
        return x >>> 1;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/vrk_in_if.sv -----
`default_nettype none
interface vrk_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [4:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] surge_velocity;
    logic signed [31:0] sway_velocity;
    logic signed [31:0] yaw_rate;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] yaw_torque;

    modport source (
        output valid, operation, coef_index, coef_value, surge_velocity,
               sway_velocity, yaw_rate, force_x, force_y, yaw_torque,
        input  ready
    );
    modport sink (
        input  valid, operation, coef_index, coef_value, surge_velocity,
               sway_velocity, yaw_rate, force_x, force_y, yaw_torque,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/vrk_out_if.sv -----
`default_nettype none
interface vrk_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] next_surge_velocity;
    logic signed [31:0] next_sway_velocity;
    logic signed [31:0] next_yaw_rate;
    logic               overflow;

    modport source (
        output valid, next_surge_velocity, next_sway_velocity, next_yaw_rate, overflow,
        input  ready
    );
    modport sink (
        input  valid, next_surge_velocity, next_sway_velocity, next_yaw_rate, overflow,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/vrk_deriv.sv -----
`default_nettype none
// one derivative evaluation, 8 stages
module vrk_deriv (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire vrk_pkg::t_ctx           i_ctx,
    input  wire vrk_pkg::t_word [2:0]    i_pt,
    input  wire vrk_pkg::t_tab           i_tab,
    input  wire vrk_pkg::t_phys          i_phys,
    output logic                         o_valid,
    output logic                         o_busy,
    output vrk_pkg::t_ctx                o_ctx,
    output vrk_pkg::t_word [2:0]         o_k
);

    logic [7:0] r_v;

    vrk_pkg::t_ctx        r_s1_ctx, r_s2_ctx, r_s3_ctx, r_s4_ctx;
    vrk_pkg::t_ctx        r_s5_ctx, r_s6_ctx, r_s7_ctx, r_s8_ctx;
    vrk_pkg::t_ctx        n_s2_ctx, n_s3_ctx, n_s5_ctx, n_s7_ctx, n_s8_ctx;
    vrk_pkg::t_word [2:0] r_s1_pt, r_s2_pt, r_s3_pt;
    vrk_pkg::t_prod       r_s1_p [5];
    vrk_pkg::t_prod       n_s1_p [5];
    vrk_pkg::t_word       r_s2_w, r_s2_mv, r_s2_mu, r_s2_xu;
    vrk_pkg::t_word       n_s2_w, n_s2_mv, n_s2_mu, n_s2_xu;
    vrk_pkg::t_word       r_s3_e [9];
    vrk_pkg::t_word       n_s3_e [9];
    vrk_pkg::t_prod       r_s4_p [9];
    vrk_pkg::t_prod       n_s4_p [9];
    vrk_pkg::t_word       r_s5_t [3];
    vrk_pkg::t_word       n_s5_t [3];
    vrk_pkg::t_prod       r_s6_p [9];
    vrk_pkg::t_prod       n_s6_p [9];
    vrk_pkg::t_word       r_s7_s [3];
    vrk_pkg::t_word       n_s7_s [3];
    vrk_pkg::t_word [2:0] r_s8_k, n_s8_k;

    assign o_valid = r_v[7];
    assign o_busy  = |r_v;
    assign o_ctx   = r_s8_ctx;
    assign o_k     = r_s8_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    // stage 1: Coriolis products
    always_comb begin
        n_s1_p[0] = vrk_pkg::f_mul(i_phys.yv,   i_pt[1]);
        n_s1_p[1] = vrk_pkg::f_mul(i_phys.yrn,  i_pt[2]);
        n_s1_p[2] = vrk_pkg::f_mul(i_phys.mass, i_pt[1]);
        n_s1_p[3] = vrk_pkg::f_mul(i_phys.mass, i_pt[0]);
        n_s1_p[4] = vrk_pkg::f_mul(i_phys.xu,   i_pt[0]);
    end

    // stage 2: scale, w
    always_comb begin
        vrk_pkg::t_sat s_yv, s_yr, s_mv, s_mu, s_xu, s_w;
        s_yv    = vrk_pkg::f_mulsat(r_s1_p[0]);
        s_yr    = vrk_pkg::f_mulsat(r_s1_p[1]);
        s_mv    = vrk_pkg::f_mulsat(r_s1_p[2]);
        s_mu    = vrk_pkg::f_mulsat(r_s1_p[3]);
        s_xu    = vrk_pkg::f_mulsat(r_s1_p[4]);
        s_w     = vrk_pkg::f_add(s_yv.v, vrk_pkg::f_half(s_yr.v));
        n_s2_w  = s_w.v;
        n_s2_mv = s_mv.v;
        n_s2_mu = s_mu.v;
        n_s2_xu = s_xu.v;
        n_s2_ctx = r_s1_ctx;
        n_s2_ctx.ovf = r_s1_ctx.ovf | i_phys.yrn_ovf | s_yv.ovf | s_yr.ovf | s_mv.ovf
                     | s_mu.ovf | s_xu.ovf | s_w.ovf;
    end

    // stage 3: C + D
    always_comb begin
        vrk_pkg::t_sat c02, c12, c20, c21, e2, e5, e6, e7;
        c02 = vrk_pkg::f_sub(r_s2_w,  r_s2_mv);
        c12 = vrk_pkg::f_sub(r_s2_mu, r_s2_xu);
        c20 = vrk_pkg::f_sub(r_s2_mv, r_s2_w);
        c21 = vrk_pkg::f_sub(r_s2_xu, r_s2_mu);
        e2  = vrk_pkg::f_add(c02.v, i_tab[2]);
        e5  = vrk_pkg::f_add(c12.v, i_tab[5]);
        e6  = vrk_pkg::f_add(c20.v, i_tab[6]);
        e7  = vrk_pkg::f_add(c21.v, i_tab[7]);
        for (int i = 0; i < 9; i++) begin
            n_s3_e[i] = i_tab[i];
        end
        n_s3_e[2] = e2.v;
        n_s3_e[5] = e5.v;
        n_s3_e[6] = e6.v;
        n_s3_e[7] = e7.v;
        n_s3_ctx  = r_s2_ctx;
        n_s3_ctx.ovf = r_s2_ctx.ovf | c02.ovf | c12.ovf | c20.ovf | c21.ovf
                     | e2.ovf | e5.ovf | e6.ovf | e7.ovf;
    end

    // stage 4: vel * (C + D)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_s4_p[i*3+j] = vrk_pkg::f_mul(r_s3_pt[j], r_s3_e[i*3+j]);
            end
        end
    end

    // stage 5: row sums
    always_comb begin
        vrk_pkg::t_sat a, b, c, s1, s2;
        logic          ov;
        ov = r_s4_ctx.ovf;
        for (int i = 0; i < 3; i++) begin
            a  = vrk_pkg::f_mulsat(r_s4_p[i*3]);
            b  = vrk_pkg::f_mulsat(r_s4_p[i*3+1]);
            c  = vrk_pkg::f_mulsat(r_s4_p[i*3+2]);
            s1 = vrk_pkg::f_add(a.v, b.v);
            s2 = vrk_pkg::f_add(s1.v, c.v);
            n_s5_t[i] = s2.v;
            ov = ov | a.ovf | b.ovf | c.ovf | s1.ovf | s2.ovf;
        end
        n_s5_ctx     = r_s4_ctx;
        n_s5_ctx.ovf = ov;
    end

    // stage 6: invM * t1
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_s6_p[i*3+j] = vrk_pkg::f_mul(i_tab[9+i*3+j], r_s5_t[j]);
            end
        end
    end

    // stage 7: row sums
    always_comb begin
        vrk_pkg::t_sat a, b, c, s1, s2;
        logic          ov;
        ov = r_s6_ctx.ovf;
        for (int i = 0; i < 3; i++) begin
            a  = vrk_pkg::f_mulsat(r_s6_p[i*3]);
            b  = vrk_pkg::f_mulsat(r_s6_p[i*3+1]);
            c  = vrk_pkg::f_mulsat(r_s6_p[i*3+2]);
            s1 = vrk_pkg::f_add(a.v, b.v);
            s2 = vrk_pkg::f_add(s1.v, c.v);
            n_s7_s[i] = s2.v;
            ov = ov | a.ovf | b.ovf | c.ovf | s1.ovf | s2.ovf;
        end
        n_s7_ctx     = r_s6_ctx;
        n_s7_ctx.ovf = ov;
    end

    // stage 8: k = F - s
    always_comb begin
        vrk_pkg::t_sat d;
        logic          ov;
        ov = r_s7_ctx.ovf;
        for (int i = 0; i < 3; i++) begin
            d         = vrk_pkg::f_sub(r_s7_ctx.frc[i], r_s7_s[i]);
            n_s8_k[i] = d.v;
            ov        = ov | d.ovf;
        end
        n_s8_ctx     = r_s7_ctx;
        n_s8_ctx.ovf = ov;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_ctx <= i_ctx;
            r_s1_pt  <= i_pt;
            r_s1_p   <= n_s1_p;
            r_s2_ctx <= n_s2_ctx;
            r_s2_pt  <= r_s1_pt;
            r_s2_w   <= n_s2_w;
            r_s2_mv  <= n_s2_mv;
            r_s2_mu  <= n_s2_mu;
            r_s2_xu  <= n_s2_xu;
            r_s3_ctx <= n_s3_ctx;
            r_s3_pt  <= r_s2_pt;
            r_s3_e   <= n_s3_e;
            r_s4_ctx <= r_s3_ctx;
            r_s4_p   <= n_s4_p;
            r_s5_ctx <= n_s5_ctx;
            r_s5_t   <= n_s5_t;
            r_s6_ctx <= r_s5_ctx;
            r_s6_p   <= n_s6_p;
            r_s7_ctx <= n_s7_ctx;
            r_s7_s   <= n_s7_s;
            r_s8_ctx <= n_s8_ctx;
            r_s8_k   <= n_s8_k;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/vessel_rk4_velocity_step_top.sv -----
`default_nettype none
// Step items pass the input register, four 8-stage derivative units, sums and output.
// Throughput: one step item per cycle unless o_out.ready stalls the output register.
// A load item is taken only while no step item is in flight; it gives no result.
// Reset (synchronous, i_rst_n low): pipe emptied, time_step = 1.0, other
// registers and the coefficient table cleared.
module vessel_rk4_velocity_step_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    vrk_in_if.sink           i_in,
    vrk_out_if.source        o_out
);

    logic                 en;
    logic                 busy;
    logic                 accept;

    logic [30:0]          r_dt;
    vrk_pkg::t_word       r_mass, r_xu, r_yv, r_yr, r_nv;
    vrk_pkg::t_tab        r_tab;
    vrk_pkg::t_phys       phys;
    vrk_pkg::t_sat        yrn;
    vrk_pkg::t_word       dt;

    logic                 r_in_v;
    vrk_pkg::t_ctx        r_in_ctx;

    logic                 d_v_in   [4];
    logic                 d_v_out  [4];
    logic                 d_busy   [4];
    vrk_pkg::t_ctx        d_ctx_in [4];
    vrk_pkg::t_ctx        d_ctx_out[4];
    vrk_pkg::t_word [2:0] d_pt_in  [4];
    vrk_pkg::t_word [2:0] d_k      [4];
    logic [2:0]           u_busy;

    logic [5:0]           r_f_v;
    vrk_pkg::t_ctx        r_f1_ctx, r_f2_ctx, r_f3_ctx, r_f4_ctx, r_f5_ctx, r_f6_ctx;
    vrk_pkg::t_ctx        n_f1_ctx, n_f2_ctx, n_f3_ctx, n_f5_ctx;
    vrk_pkg::t_word [2:0] r_f1_a, r_f1_b, r_f1_k4, r_f2_x, r_f2_y, r_f3_s;
    vrk_pkg::t_word [2:0] n_f1_a, n_f1_b, n_f2_x, n_f2_y, n_f3_s;
    vrk_pkg::t_prod       r_f4_p [3];
    logic [31:0]          r_f5_z [3];
    logic [31:0]          n_f5_z [3];
    logic [63:0]          r_f6_p [3];

    logic                 r_o_v;
    vrk_pkg::t_word [2:0] r_o_vel, n_o_vel;
    logic                 r_o_ovf, n_o_ovf;

    assign en     = !r_o_v || o_out.ready;
    assign busy   = r_in_v || d_busy[0] || d_busy[1] || d_busy[2] || d_busy[3]
                  || (|u_busy) || (|r_f_v) || r_o_v;
    assign i_in.ready = en && !(i_in.operation == vrk_pkg::OP_LOAD && busy);
    assign accept = i_in.valid && i_in.ready;

    // configuration and coefficient table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt   <= 31'd65536;
            r_mass <= '0;
            r_xu   <= '0;
            r_yv   <= '0;
            r_yr   <= '0;
            r_nv   <= '0;
            r_tab  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vrk_pkg::CFG_TIME_STEP: r_dt   <= i_cfg_data[30:0];
                    vrk_pkg::CFG_MASS:      r_mass <= i_cfg_data;
                    vrk_pkg::CFG_XU:        r_xu   <= i_cfg_data;
                    vrk_pkg::CFG_YV:        r_yv   <= i_cfg_data;
                    vrk_pkg::CFG_YR:        r_yr   <= i_cfg_data;
                    vrk_pkg::CFG_NV:        r_nv   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept && i_in.operation == vrk_pkg::OP_LOAD
                && i_in.coef_index < 5'(vrk_pkg::NCOEF)) begin
                r_tab[i_in.coef_index] <= i_in.coef_value;
            end
        end
    end

    assign yrn          = vrk_pkg::f_add(r_yr, r_nv);
    assign phys.mass    = r_mass;
    assign phys.xu      = r_xu;
    assign phys.yv      = r_yv;
    assign phys.yrn     = yrn.v;
    assign phys.yrn_ovf = yrn.ovf;
    assign dt           = {1'b0, r_dt};

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en) begin
            r_in_v <= accept && i_in.operation == vrk_pkg::OP_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_ctx.vel[0] <= i_in.surge_velocity;
            r_in_ctx.vel[1] <= i_in.sway_velocity;
            r_in_ctx.vel[2] <= i_in.yaw_rate;
            r_in_ctx.frc[0] <= i_in.force_x;
            r_in_ctx.frc[1] <= i_in.force_y;
            r_in_ctx.frc[2] <= i_in.yaw_torque;
            r_in_ctx.k      <= '0;
            r_in_ctx.ovf    <= 1'b0;
        end
    end

    assign d_v_in[0]   = r_in_v;
    assign d_ctx_in[0] = r_in_ctx;
    assign d_pt_in[0]  = r_in_ctx.vel;

    for (genvar g = 0; g < 4; g++) begin : g_eval
        vrk_deriv u_deriv (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d_v_in[g]),
            .i_ctx   (d_ctx_in[g]),
            .i_pt    (d_pt_in[g]),
            .i_tab   (r_tab),
            .i_phys  (phys),
            .o_valid (d_v_out[g]),
            .o_busy  (d_busy[g]),
            .o_ctx   (d_ctx_out[g]),
            .o_k     (d_k[g])
        );

        if (g < 3) begin : g_upd
            logic                 r_u1_v, r_u2_v;
            vrk_pkg::t_ctx        r_u1_ctx, n_u1_ctx, r_u2_ctx, n_u2_ctx;
            vrk_pkg::t_prod       r_u1_p [3];
            vrk_pkg::t_prod       n_u1_p [3];
            vrk_pkg::t_word [2:0] r_u2_pt, n_u2_pt;

            always_comb begin
                n_u1_ctx      = d_ctx_out[g];
                n_u1_ctx.k[g] = d_k[g];
                for (int i = 0; i < 3; i++) begin
                    n_u1_p[i] = vrk_pkg::f_mul(dt, d_k[g][i]);
                end
            end

            // half step for the first two, full step for the third
            always_comb begin
                vrk_pkg::t_sat  m, a;
                vrk_pkg::t_word h;
                logic           ov;
                ov = r_u1_ctx.ovf;
                for (int i = 0; i < 3; i++) begin
                    m = vrk_pkg::f_mulsat(r_u1_p[i]);
                    h = (g < 2) ? vrk_pkg::f_half(m.v) : m.v;
                    a = vrk_pkg::f_add(r_u1_ctx.vel[i], h);
                    n_u2_pt[i] = a.v;
                    ov = ov | m.ovf | a.ovf;
                end
                n_u2_ctx     = r_u1_ctx;
                n_u2_ctx.ovf = ov;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_u1_v <= 1'b0;
                    r_u2_v <= 1'b0;
                end else if (en) begin
                    r_u1_v <= d_v_out[g];
                    r_u2_v <= r_u1_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_u1_ctx <= n_u1_ctx;
                    r_u1_p   <= n_u1_p;
                    r_u2_ctx <= n_u2_ctx;
                    r_u2_pt  <= n_u2_pt;
                end
            end

            assign u_busy[g]     = r_u1_v || r_u2_v;
            assign d_v_in[g+1]   = r_u2_v;
            assign d_ctx_in[g+1] = r_u2_ctx;
            assign d_pt_in[g+1]  = r_u2_pt;
        end
    end

    // weighted sum k1 + 2k2 + 2k3 + k4, per component
    always_comb begin
        vrk_pkg::t_sat a, b;
        logic          ov;
        ov = d_ctx_out[3].ovf;
        for (int i = 0; i < 3; i++) begin
            a = vrk_pkg::f_add(d_ctx_out[3].k[1][i], d_ctx_out[3].k[1][i]);
            b = vrk_pkg::f_add(d_ctx_out[3].k[2][i], d_ctx_out[3].k[2][i]);
            n_f1_a[i] = a.v;
            n_f1_b[i] = b.v;
            ov = ov | a.ovf | b.ovf;
        end
        n_f1_ctx     = d_ctx_out[3];
        n_f1_ctx.ovf = ov;
    end

    always_comb begin
        vrk_pkg::t_sat x, y;
        logic          ov;
        ov = r_f1_ctx.ovf;
        for (int i = 0; i < 3; i++) begin
            x = vrk_pkg::f_add(r_f1_ctx.k[0][i], r_f1_a[i]);
            y = vrk_pkg::f_add(r_f1_b[i], r_f1_k4[i]);
            n_f2_x[i] = x.v;
            n_f2_y[i] = y.v;
            ov = ov | x.ovf | y.ovf;
        end
        n_f2_ctx     = r_f1_ctx;
        n_f2_ctx.ovf = ov;
    end

    always_comb begin
        vrk_pkg::t_sat s;
        logic          ov;
        ov = r_f2_ctx.ovf;
        for (int i = 0; i < 3; i++) begin
            s         = vrk_pkg::f_add(r_f2_x[i], r_f2_y[i]);
            n_f3_s[i] = s.v;
            ov        = ov | s.ovf;
        end
        n_f3_ctx     = r_f2_ctx;
        n_f3_ctx.ovf = ov;
    end

    // floor(x/6) = floor(floor(x/2)/3); offset by 3 * 2^30 so the divide runs unsigned
    always_comb begin
        vrk_pkg::t_sat m;
        logic [31:0]   h;
        logic          ov;
        ov = r_f4_ctx.ovf;
        for (int i = 0; i < 3; i++) begin
            m         = vrk_pkg::f_mulsat(r_f4_p[i]);
            h         = vrk_pkg::f_half(m.v);
            n_f5_z[i] = h + 32'hC000_0000;
            ov        = ov | m.ovf;
        end
        n_f5_ctx     = r_f4_ctx;
        n_f5_ctx.ovf = ov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= '0;
        end else if (en) begin
            r_f_v <= {r_f_v[4:0], d_v_out[3]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_ctx <= n_f1_ctx;
            r_f1_a   <= n_f1_a;
            r_f1_b   <= n_f1_b;
            r_f1_k4  <= d_k[3];
            r_f2_ctx <= n_f2_ctx;
            r_f2_x   <= n_f2_x;
            r_f2_y   <= n_f2_y;
            r_f3_ctx <= n_f3_ctx;
            r_f3_s   <= n_f3_s;
            r_f4_ctx <= r_f3_ctx;
            r_f5_ctx <= n_f5_ctx;
            r_f5_z   <= n_f5_z;
            r_f6_ctx <= r_f5_ctx;
            for (int i = 0; i < 3; i++) begin
                r_f4_p[i] <= vrk_pkg::f_mul(dt, r_f3_s[i]);
                // z / 3 by reciprocal: (z * 0xAAAAAAAB) >> 33, exact for 32-bit z
                r_f6_p[i] <= 64'(r_f5_z[i]) * 64'h0000_0000_AAAA_AAAB;
            end
        end
    end

    // quotient minus 2^30 undoes the offset
    always_comb begin
        vrk_pkg::t_sat r;
        logic [31:0]   q;
        logic          ov;
        ov = r_f6_ctx.ovf;
        for (int i = 0; i < 3; i++) begin
            q          = {1'b0, r_f6_p[i][63:33]} - 32'h4000_0000;
            r          = vrk_pkg::f_add(r_f6_ctx.vel[i], vrk_pkg::t_word'(q));
            n_o_vel[i] = r.v;
            ov         = ov | r.ovf;
        end
        n_o_ovf = ov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en) begin
            r_o_v <= r_f_v[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_vel <= n_o_vel;
            r_o_ovf <= n_o_ovf;
        end
    end

    assign o_out.valid               = r_o_v;
    assign o_out.next_surge_velocity = r_o_vel[0];
    assign o_out.next_sway_velocity  = r_o_vel[1];
    assign o_out.next_yaw_rate       = r_o_vel[2];
    assign o_out.overflow            = r_o_ovf;

endmodule
`default_nettype wire
